>>> src/pcd_pkg.sv
// Shared types and codes of the partitioned circular deque.
package pcd_pkg;

  localparam int ACTION_W = 2;
  localparam int SEL_W    = 2;
  localparam int FIELD_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } pcd_action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } pcd_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } pcd_cmd_t;

endpackage

>>> src/pcd_if.sv
// Valid/ready channel interfaces for the deque's input and result items.
interface pcd_in_if import pcd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic [SEL_W-1:0]          queue_sel;
  logic signed [FIELD_W-1:0] data_in;

  modport source (output valid, action, queue_sel, data_in, input ready);
  modport sink   (input valid, action, queue_sel, data_in, output ready);
endinterface

interface pcd_out_if import pcd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] data_out;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, data_out, status, input ready);
  modport sink   (input valid, data_out, status, output ready);
endinterface

>>> src/pcd_ctrl.sv
// Sequencing state machine of the deque: accept, execute, present result.
module pcd_ctrl import pcd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_ready,
  output logic     in_ready,
  output logic     out_valid,
  output pcd_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } pcd_state_t;

  pcd_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_RESP);
  assign cmd.capture = in_ready && in_valid;
  assign cmd.exec    = (state_r == S_EXEC);

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.exec)
    else $error("accepted item did not move to execution");

  a_exec_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid && !in_ready)
    else $error("execution not followed by a result");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input open while a result is pending");

endmodule

>>> src/pcd_datapath.sv
// Segment pointers, storage array and result registers of the deque.
module pcd_datapath import pcd_pkg::*; #(
  parameter int TOTAL_DEPTH = 128,
  parameter int NUM_PARTS   = 4,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pcd_cmd_t                  cmd,
  input  logic [ACTION_W-1:0]       in_action,
  input  logic [SEL_W-1:0]          in_queue_sel,
  input  logic signed [FIELD_W-1:0] in_data_in,
  output logic signed [FIELD_W-1:0] out_data_out,
  output logic [STATUS_W-1:0]       out_status
);

  localparam int SEG_SIZE = TOTAL_DEPTH / NUM_PARTS;
  localparam bit SEG_ZERO = (SEG_SIZE == 0);
  localparam int SEG_W    = (SEG_SIZE > 1) ? $clog2(SEG_SIZE) : 1;
  localparam int SEG_LAST = (SEG_SIZE > 0) ? SEG_SIZE - 1 : 0;
  localparam int PART_W   = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int ADDR_W   = $clog2(TOTAL_DEPTH);
  localparam int KEEP_W   = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;

  typedef logic [SEG_W-1:0] idx_t;

  function automatic idx_t step_up(idx_t i);
    idx_t res;
    if (i == idx_t'(SEG_LAST)) res = '0;
    else res = i + idx_t'(1);
    return res;
  endfunction

  function automatic idx_t step_down(idx_t i);
    idx_t res;
    if (i == '0) res = idx_t'(SEG_LAST);
    else res = i - idx_t'(1);
    return res;
  endfunction

  // Captured item
  pcd_action_t             act_r;
  logic [PART_W-1:0]       part_r, part_nxt;
  logic [DATA_WIDTH-1:0]   wdata_r, wdata_nxt;

  // Per-segment state
  idx_t                    front_r [NUM_PARTS];
  idx_t                    rear_r  [NUM_PARTS];
  logic [NUM_PARTS-1:0]    empty_r;

  // Storage and result
  logic [DATA_WIDTH-1:0]   mem [TOTAL_DEPTH];
  logic [DATA_WIDTH-1:0]   rdata_r;
  logic                    res_pop_r;
  pcd_status_t             res_status_r;

  // Selector wraps onto the existing segments.
  generate
    if (NUM_PARTS >= 4) begin : g_sel_direct
      assign part_nxt = PART_W'(in_queue_sel);
    end else begin : g_sel_wrap
      always_comb begin
        logic [SEL_W-1:0] p;
        p = in_queue_sel;
        for (int k = 0; k < 3; k++) begin
          if (p >= SEL_W'(NUM_PARTS)) p = p - SEL_W'(NUM_PARTS);
        end
        part_nxt = PART_W'(p);
      end
    end
  endgenerate

  always_comb begin
    wdata_nxt = '0;
    wdata_nxt[KEEP_W-1:0] = in_data_in[KEEP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= pcd_action_t'(in_action);
      part_r  <= part_nxt;
      wdata_r <= wdata_nxt;
    end
  end

  // Execution decision for the captured item
  idx_t        f_cur, r_cur, f_nxt, r_nxt, acc_idx;
  logic        e_cur, e_nxt, wr_en, rd_en, is_push;
  pcd_status_t status_nxt;
  logic [ADDR_W-1:0] acc_addr;

  always_comb begin
    f_cur      = front_r[part_r];
    r_cur      = rear_r[part_r];
    e_cur      = empty_r[part_r];
    f_nxt      = f_cur;
    r_nxt      = r_cur;
    e_nxt      = e_cur;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    acc_idx    = f_cur;
    status_nxt = ST_DONE;
    is_push    = (act_r == ACT_PUSH_FRONT) || (act_r == ACT_PUSH_REAR);
    if (is_push) begin
      priority if (SEG_ZERO) begin
        status_nxt = ST_FULL;
      end else if (e_cur) begin
        f_nxt   = '0;
        r_nxt   = '0;
        e_nxt   = 1'b0;
        wr_en   = 1'b1;
        acc_idx = '0;
      end else if (f_cur == step_up(r_cur)) begin
        status_nxt = ST_FULL;
      end else if (act_r == ACT_PUSH_FRONT) begin
        f_nxt   = step_down(f_cur);
        wr_en   = 1'b1;
        acc_idx = step_down(f_cur);
      end else begin
        r_nxt   = step_up(r_cur);
        wr_en   = 1'b1;
        acc_idx = step_up(r_cur);
      end
    end else begin
      priority if (SEG_ZERO || e_cur) begin
        status_nxt = ST_EMPTY;
      end else if (f_cur == r_cur) begin
        // Last element leaves: segment goes back to its reset shape.
        rd_en   = 1'b1;
        acc_idx = f_cur;
        f_nxt   = '0;
        r_nxt   = '0;
        e_nxt   = 1'b1;
      end else if (act_r == ACT_POP_FRONT) begin
        rd_en   = 1'b1;
        acc_idx = f_cur;
        f_nxt   = step_up(f_cur);
      end else begin
        rd_en   = 1'b1;
        acc_idx = r_cur;
        r_nxt   = step_down(r_cur);
      end
    end
    acc_addr = ADDR_W'(part_r) * ADDR_W'(SEG_SIZE) + ADDR_W'(acc_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PARTS; i++) begin
        front_r[i] <= '0;
        rear_r[i]  <= '0;
      end
      empty_r <= '1;
    end else if (cmd.exec) begin
      front_r[part_r] <= f_nxt;
      rear_r[part_r]  <= r_nxt;
      empty_r[part_r] <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[acc_addr] <= wdata_r;
    if (cmd.exec && rd_en) rdata_r <= mem[acc_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_pop_r    <= 1'b0;
      res_status_r <= ST_DONE;
    end else if (cmd.exec) begin
      res_pop_r    <= rd_en;
      res_status_r <= status_nxt;
    end
  end

  always_comb begin
    out_data_out = '0;
    if (res_pop_r) out_data_out[KEEP_W-1:0] = rdata_r[KEEP_W-1:0];
  end
  assign out_status = res_status_r;

  a_empty_pointers: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r[part_r] |-> (front_r[part_r] == '0) && (rear_r[part_r] == '0))
    else $error("empty segment with nonzero pointers");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && !is_push && empty_r[part_r] |=> res_status_r == ST_EMPTY && !res_pop_r)
    else $error("pop from empty segment not refused");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && is_push && status_nxt == ST_DONE |=> !empty_r[$past(part_r)])
    else $error("segment still empty after a push");

endmodule

>>> src/partitioned_circular_deque.sv
// Partitioned circular deque: top level joining controller and datapath.
//
// One storage array of TOTAL_DEPTH entries is split into NUM_PARTS equal
// segments, each an independent circular double-ended queue.
// Input channel in_ch carries action (push front, push rear, pop front,
// pop rear), queue_sel and data_in; queue_sel wraps onto the segments.
// Result channel out_ch carries one item per input item: data_out (the
// popped value, zero otherwise) and status (done, full or empty).
// In the cycle after an item is accepted the segment pointers are updated and
// the one storage write or read is done; read data and status are registered
// then and presented on out_ch as the result.
// Only one item is in flight at a time: a new item is taken only after the
// result of the last one has been taken on out_ch.
// A stalled receiver holds the result steady; in_ch.ready stays low until
// the result is taken.
// Reset (rst_n, synchronous, active low) marks every segment empty with both
// pointers at zero; the storage is not cleared and needs no clearing pass.
module partitioned_circular_deque import pcd_pkg::*; #(
  parameter int TOTAL_DEPTH = 128,
  parameter int NUM_PARTS   = 4,
  parameter int DATA_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  pcd_in_if.sink    in_ch,
  pcd_out_if.source out_ch
);

  pcd_cmd_t cmd;

  pcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  pcd_datapath #(
    .TOTAL_DEPTH (TOTAL_DEPTH),
    .NUM_PARTS   (NUM_PARTS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_action    (in_ch.action),
    .in_queue_sel (in_ch.queue_sel),
    .in_data_in   (in_ch.data_in),
    .out_data_out (out_ch.data_out),
    .out_status   (out_ch.status)
  );

endmodule
